// File: hw/rtl/sclc_pkg.sv
// Package for the closed-loop stepper controller: constants, payload types, states, helpers.
`timescale 1ns / 1ps
`default_nettype none
package sclc_pkg;

  localparam int TC_BITS       = 15;
  localparam int STEP_ANGLE    = 461;
  localparam int HALF_TURN     = 46080;
  localparam int FULL_TURN     = 92160;
  localparam int POS_ILIM      = 150 * 256;
  localparam int VEL_ILIM      = 200 * 256;
  localparam int HYBRID_EFFORT = 69;
  localparam int BUSY_BAND     = 25;

  // Serial multiplier: multiplier bits, multiplicand and accumulator width.
  localparam int MUL_BITS = 25;
  localparam int MCAND_W  = 59;
  // Serial divider by five: dividend bits.
  localparam int DIV_BITS = 34;
  // Width of rounded products and effort sums.
  localparam int WIDE_W   = 44;
  localparam int INTEG_W  = 17;

  localparam logic [2:0] MODE_POS = 3'd1;
  localparam logic [2:0] MODE_VEL = 3'd2;
  localparam logic [2:0] MODE_TRQ = 3'd3;
  localparam logic [2:0] MODE_HYB = 3'd4;

  localparam logic [2:0] CFG_MODE = 3'd0;
  localparam logic [2:0] CFG_KP   = 3'd1;
  localparam logic [2:0] CFG_KI   = 3'd2;
  localparam logic [2:0] CFG_KD   = 3'd3;
  localparam logic [2:0] CFG_KEEP = 3'd4;
  localparam logic [2:0] CFG_TAKE = 3'd5;
  localparam logic [2:0] CFG_PA   = 3'd6;
  localparam logic [2:0] CFG_ELIM = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TURN, ST_POS, ST_DPOS, ST_PERR, ST_MSTART, ST_MUL, ST_MACC,
    ST_VERR, ST_HYB, ST_HPREP, ST_DIV, ST_LIMIT, ST_FIN
  } state_t;

  typedef struct packed {
    logic [16:0]        shaft_angle;
    logic signed [31:0] setpoint;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] coil_angle;
    logic [7:0]         effort;
    logic               busy_res;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [31:0] res;
    if (x > $signed(44'sh0007FFFFFFF)) begin
      res = 32'sh7FFFFFFF;
    end else if (x < $signed(-44'sh00080000000)) begin
      res = 32'sh80000000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [INTEG_W-1:0] clampi(input logic signed [WIDE_W-1:0] x,
                                                       input logic signed [WIDE_W-1:0] lim);
    logic signed [INTEG_W-1:0] res;
    logic signed [WIDE_W-1:0]  nlim;
    nlim = -lim;
    if (x > lim) begin
      res = lim[INTEG_W-1:0];
    end else if (x < nlim) begin
      res = nlim[INTEG_W-1:0];
    end else begin
      res = x[INTEG_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/stepper_closed_loop_controller.sv
// Top level of the closed-loop stepper controller with serial multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none
// One control tick is one transfer on the input channel and one on the result channel.
// The tick is worked through by a sequencer around one bit-serial shift-add multiplier
// (a setup state, the shift-add states and an accumulation state per product). Position
// and velocity modes take five products each. Hybrid stepping runs a bit-serial divide
// by five over 34 dividend bits. Torque mode and the unused mode codes skip both the
// multiplier and the divider. The input stalls while a tick is in work; a finished
// result sits in the output register, so a new tick can be taken while it waits.
// Configuration writes are taken at any cycle but belong to idle periods.
module stepper_closed_loop_controller
  import sclc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata
);

  // Configuration registers.
  logic [2:0]         mode_r;
  logic signed [23:0] kp_r, ki_r, kd_r;
  logic [15:0]        keep_r, take_r;
  logic [14:0]        pa_r;
  logic [7:0]         elim_r;

  // Controller state kept across ticks.
  logic [16:0]               last_y_r;
  logic signed [TC_BITS-1:0] tc_r;
  logic signed [31:0]        last_pos_r, deriv_r, vel_r, err_r, last_err_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [15:0]        missed_r;

  // Working registers of the current tick.
  state_t                    state_r, state_nxt;
  logic [16:0]               y_r;
  logic signed [31:0]        r_r, pos_r;
  logic signed [32:0]        dpos_r;
  logic signed [WIDE_W-1:0]  tmp_r, u_r;
  logic signed [24:0]        tk_r;
  logic [2:0]                mi_r;
  logic signed [MCAND_W-1:0] mcand_r, acc_r;
  logic [MUL_BITS-1:0]       mplier_r;
  logic [5:0]                cnt_r;
  logic [DIV_BITS-1:0]       quo_r;
  logic [2:0]                rem_r;
  logic                      qneg_r, adv_pos_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;

  localparam logic signed [TC_BITS-1:0] TC_MAX = {1'b0, {(TC_BITS-1){1'b1}}};
  localparam logic signed [TC_BITS-1:0] TC_MIN = {1'b1, {(TC_BITS-1){1'b0}}};

  logic fin_go;

  // Handshake and sequencing outputs.
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    fin_go   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Turn detection against the previous angle.
  logic signed [17:0] dturn;
  assign dturn = $signed({1'b0, y_r}) - $signed({1'b0, last_y_r});

  // Multi-turn position, saturated to 32 bits.
  logic signed [39:0] pos_w;
  assign pos_w = $signed({23'b0, y_r}) + $signed(tc_r) * 40'sd92160;

  // Rounded product of the serial multiplier: floor((p + 2^15) / 2^16).
  logic signed [MCAND_W-1:0] acc_rnd;
  logic signed [WIDE_W-1:0]  pr;
  assign acc_rnd = acc_r + $signed(MCAND_W'(32768));
  assign pr      = $signed({acc_rnd[MCAND_W-1], acc_rnd[MCAND_W-1:16]});

  // Operand selection for the next product.
  logic signed [33:0] opa;
  logic signed [24:0] opb;
  always_comb begin
    opa = '0;
    opb = '0;
    if (mode_r == MODE_POS) begin
      unique case (mi_r)
        3'd0: begin opa = 34'(err_r);   opb = 25'(ki_r); end
        3'd1: begin opa = 34'(deriv_r); opb = $signed({9'b0, keep_r}); end
        3'd2: begin opa = 34'(kd_r);    opb = $signed({9'b0, take_r}); end
        3'd3: begin opa = 34'(dpos_r);  opb = tk_r; end
        default: begin opa = 34'(err_r); opb = 25'(kp_r); end
      endcase
    end else begin
      unique case (mi_r)
        3'd0: begin opa = 34'(vel_r);   opb = $signed({9'b0, keep_r}); end
        3'd1: begin opa = 34'(dpos_r);  opb = $signed({9'b0, take_r}); end
        3'd2: begin opa = 34'(err_r);   opb = 25'(ki_r); end
        3'd3: begin opa = 34'($signed(33'(err_r)) - $signed(33'(last_err_r)));
                    opb = 25'(kd_r); end
        default: begin opa = 34'(err_r); opb = 25'(kp_r); end
      endcase
    end
  end

  // One multiplier bit per cycle; the top bit of the multiplier has negative weight.
  logic                      mul_last;
  logic signed [MCAND_W-1:0] addend;
  assign mul_last = (cnt_r == 6'(MUL_BITS - 1));
  assign addend   = mplier_r[0] ? mcand_r : '0;

  // Hybrid stepping: x = 40 - 9*(r - 256*missed), then floor(x/80) = floor(floor(x/16)/5).
  logic signed [33:0] hdiff;
  logic signed [37:0] hx, hx16, hn;
  assign hdiff = $signed(34'(r_r)) - $signed({{10{missed_r[15]}}, missed_r, 8'b0});
  assign hx    = 38'sd40 - ($signed(38'(hdiff)) * 38'sd9);
  assign hx16  = hx >>> 4;
  assign hn    = hx16[37] ? (38'sd4 - hx16) : hx16;

  // Restoring division by five, one quotient bit per cycle.
  logic [3:0] dtrial;
  logic       dge;
  assign dtrial = {rem_r, quo_r[DIV_BITS-1]};
  assign dge    = (dtrial >= 4'd5);

  // Result assembly.
  logic signed [18:0] coil_sum;
  logic signed [31:0] coil_loop, coil_hyb;
  logic [16:0]        u_mag;
  logic [16:0]        u_mag_rnd;
  logic signed [WIDE_W-1:0] umax;
  assign coil_sum  = adv_pos_r ? ($signed({2'b0, y_r}) + $signed({4'b0, pa_r}))
                               : ($signed({2'b0, y_r}) - $signed({4'b0, pa_r}));
  assign coil_loop = -$signed(32'(coil_sum));
  assign coil_hyb  = qneg_r ? -$signed(quo_r[31:0]) : $signed(quo_r[31:0]);
  assign u_mag     = u_r[WIDE_W-1] ? 17'(-u_r) : u_r[16:0];
  assign u_mag_rnd = u_mag + 17'd128;
  assign umax      = $signed({28'b0, elim_r, 8'b0});

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_TURN;
      ST_TURN:   state_nxt = ST_POS;
      ST_POS:    state_nxt = ST_DPOS;
      ST_DPOS: begin
        unique case (mode_r)
          MODE_POS: state_nxt = ST_PERR;
          MODE_VEL: state_nxt = ST_MSTART;
          MODE_HYB: state_nxt = ST_HYB;
          default:  state_nxt = ST_LIMIT;
        endcase
      end
      ST_PERR:   state_nxt = ST_MSTART;
      ST_MSTART: state_nxt = ST_MUL;
      ST_MUL:    if (mul_last) state_nxt = ST_MACC;
      ST_MACC: begin
        priority if (mi_r == 3'd4) state_nxt = ST_LIMIT;
        else if (mode_r == MODE_VEL && mi_r == 3'd1) state_nxt = ST_VERR;
        else state_nxt = ST_MSTART;
      end
      ST_VERR:   state_nxt = ST_MSTART;
      ST_HYB:    state_nxt = ST_HPREP;
      ST_HPREP:  state_nxt = ST_DIV;
      ST_DIV:    if (cnt_r == 6'(DIV_BITS - 1)) state_nxt = ST_FIN;
      ST_LIMIT:  state_nxt = ST_FIN;
      ST_FIN:    if (fin_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0; kp_r <= '0; ki_r <= '0; kd_r <= '0;
      keep_r <= '0; take_r <= '0; pa_r <= '0; elim_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MODE: mode_r <= cfg_wdata[2:0];
        CFG_KP:   kp_r   <= cfg_wdata;
        CFG_KI:   ki_r   <= cfg_wdata;
        CFG_KD:   kd_r   <= cfg_wdata;
        CFG_KEEP: keep_r <= cfg_wdata[15:0];
        CFG_TAKE: take_r <= cfg_wdata[15:0];
        CFG_PA:   pa_r   <= cfg_wdata[14:0];
        CFG_ELIM: elim_r <= cfg_wdata[7:0];
        default:  mode_r <= mode_r;
      endcase
    end
  end

  // Controller state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_y_r <= '0; tc_r <= '0; last_pos_r <= '0; integ_r <= '0;
      deriv_r <= '0; vel_r <= '0; err_r <= '0; last_err_r <= '0;
      missed_r <= '0; out_valid_r <= 1'b0; rem_r <= '0;
    end else begin
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_TURN: begin
          if (dturn < -18'sd46080) begin
            if (tc_r != TC_MAX) tc_r <= tc_r + 1'b1;
          end else if (dturn > 18'sd46080) begin
            if (tc_r != TC_MIN) tc_r <= tc_r - 1'b1;
          end
        end
        ST_PERR: err_r <= sat32($signed(44'(r_r)) - $signed(44'(pos_r)));
        ST_VERR: err_r <= sat32($signed(44'(r_r)) - $signed(44'(vel_r)));
        ST_MACC: begin
          if (mode_r == MODE_POS) begin
            unique case (mi_r)
              3'd0: integ_r <= clampi(pr + 44'(integ_r), 44'(POS_ILIM));
              3'd3: deriv_r <= sat32(tmp_r - pr);
              default: ;
            endcase
          end else begin
            unique case (mi_r)
              3'd1: vel_r   <= sat32(tmp_r + pr);
              3'd2: integ_r <= clampi(pr + 44'(integ_r), 44'(VEL_ILIM));
              default: ;
            endcase
          end
        end
        ST_HYB: begin
          if ($signed(34'(pos_r)) < $signed(34'(r_r)) - 34'(STEP_ANGLE)) begin
            if (missed_r != 16'sh8000) missed_r <= missed_r - 1'b1;
          end else if ($signed(34'(pos_r)) > $signed(34'(r_r)) + 34'(STEP_ANGLE)) begin
            if (missed_r != 16'sh7FFF) missed_r <= missed_r + 1'b1;
          end
        end
        ST_HPREP: rem_r <= '0;
        ST_DIV:   rem_r <= dge ? 3'(dtrial - 4'd5) : dtrial[2:0];
        ST_FIN: begin
          if (fin_go) begin
            last_err_r  <= err_r;
            last_pos_r  <= pos_r;
            if (mode_r != MODE_HYB) last_y_r <= y_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Working datapath and sequencing counters; these registers are not reset.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          y_r <= in_data.shaft_angle;
          r_r <= in_data.setpoint;
        end
      end
      ST_POS: pos_r <= sat32({{4{pos_w[39]}}, pos_w});
      ST_DPOS: begin
        dpos_r <= $signed(33'(pos_r)) - $signed(33'(last_pos_r));
        mi_r   <= '0;
        u_r    <= (mode_r == MODE_TRQ) ? 44'(r_r) : '0;
      end
      ST_MSTART: begin
        mcand_r  <= MCAND_W'(opa);
        mplier_r <= opb;
        acc_r    <= '0;
        cnt_r    <= '0;
      end
      ST_MUL: begin
        acc_r    <= mul_last ? (acc_r - addend) : (acc_r + addend);
        mcand_r  <= mcand_r <<< 1;
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r + 1'b1;
      end
      ST_MACC: begin
        mi_r <= mi_r + 1'b1;
        if (mode_r == MODE_POS) begin
          unique case (mi_r)
            3'd1: tmp_r <= pr;
            3'd2: tk_r  <= pr[24:0];
            3'd4: u_r   <= pr + 44'(integ_r) + 44'(deriv_r);
            default: ;
          endcase
        end else begin
          unique case (mi_r)
            3'd0: tmp_r <= pr;
            3'd3: tmp_r <= pr;
            3'd4: u_r   <= pr + 44'(integ_r) - tmp_r;
            default: ;
          endcase
        end
      end
      ST_HPREP: begin
        quo_r  <= hn[DIV_BITS-1:0];
        qneg_r <= hx16[37];
        cnt_r  <= '0;
      end
      ST_DIV: begin
        quo_r <= {quo_r[DIV_BITS-2:0], dge};
        cnt_r <= cnt_r + 1'b1;
      end
      ST_LIMIT: begin
        if (u_r > 44'sd0) begin
          adv_pos_r <= 1'b1;
          if (u_r > umax) u_r <= umax;
        end else begin
          adv_pos_r <= 1'b0;
          if (u_r < -umax) u_r <= -umax;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          out_data_r.coil_angle <= (mode_r == MODE_HYB) ? coil_hyb : coil_loop;
          out_data_r.effort     <= (mode_r == MODE_HYB) ? 8'(HYBRID_EFFORT)
                                                        : u_mag_rnd[15:8];
          out_data_r.busy_res   <= (err_r >= -32'sd25) && (err_r <= 32'sd25);
        end
      end
      default: ;
    endcase
  end

  // The result register is loaded exactly when the sequencer leaves its final state.
  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && fin_go) |=> out_valid_r)
    else $error("result not presented after final state");

  // A finished result is never overwritten while the receiver stalls.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !fin_go)
    else $error("result overwritten under stall");

  // The integral term stays inside the wider of the two clamp bands.
  a_integ_band: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= 17'sd51200) && (integ_r >= -17'sd51200))
    else $error("integral outside clamp band");

  // The divider remainder stays below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < 3'd5)
    else $error("divider remainder out of range");

endmodule
`default_nettype wire
